@@ design/lsrwe_pkg.sv @@
// shared types and constants for the lcd spi register write encoder
// no dependencies
package lsrwe_pkg;

   typedef enum logic [1:0] {
      CMD_BANKED_WRITE = 2'd0,
      CMD_SECOND_WRITE = 2'd1,
      CMD_BROADCAST    = 2'd2,
      CMD_BANKED_READ  = 2'd3
   } command_type;

   localparam logic [7:0]  BANK_SELECT_ADDR = 8'hEF;
   localparam logic [7:0]  ADDR_MAX         = 8'hFF;
   localparam logic [15:0] WORD_BANK_SELECT = 16'h00EF;
   localparam logic [15:0] WORD_DATA        = 16'h0100;
   localparam logic [15:0] WORD_SECOND_ADDR = 16'h8000;
   localparam logic [15:0] WORD_SECOND_DATA = 16'h8100;
   localparam logic [15:0] WORD_BCAST_ADDR  = 16'hC000;
   localparam logic [15:0] WORD_BCAST_DATA  = 16'hC100;
   localparam logic [15:0] WORD_READ_DUMMY  = 16'h2000;

   localparam int unsigned MAX_WORDS = 4;

   typedef struct packed {
      logic [MAX_WORDS-1:0][15:0] words;
      logic [1:0]                 last_index;
      logic                       is_read;
   } plan_type;

   typedef struct packed {
      logic     valid;
      plan_type plan;
   } head_type;

endpackage

@@ design/lsrwe_front.sv @@
// front end: accepts accesses, checks the address caches and builds a word plan
// depends on lsrwe_pkg
module lsrwe_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_command,
   input  logic [7:0]         req_bank,
   input  logic [7:0]         req_address,
   input  logic [7:0]         req_data,
   input  logic               queue_full,
   output logic               push,
   output lsrwe_pkg::plan_type plan
);
   import lsrwe_pkg::*;

   logic [7:0] bank_ff, bank_in;
   logic       bank_valid_ff, bank_valid_in;
   logic [7:0] sub_ff, sub_in;
   logic       sub_valid_ff, sub_valid_in;
   logic [7:0] second_ff, second_in;
   logic       second_valid_ff, second_valid_in;

   assign push = req_valid && !queue_full;

   always_comb begin
      logic [1:0] pos;
      logic       bank_change;
      logic       sub_hit;
      pos             = 2'd0;
      bank_change     = 1'b0;
      sub_hit         = 1'b0;
      plan            = '0;
      bank_in         = bank_ff;
      bank_valid_in   = bank_valid_ff;
      sub_in          = sub_ff;
      sub_valid_in    = sub_valid_ff;
      second_in       = second_ff;
      second_valid_in = second_valid_ff;
      unique case (command_type'(req_command))
         CMD_BANKED_WRITE: begin
            bank_change = (!bank_valid_ff || bank_ff != req_bank)
                          && req_address != BANK_SELECT_ADDR;
            if (bank_change) begin
               plan.words[pos] = WORD_BANK_SELECT;
               pos = pos + 2'd1;
               plan.words[pos] = WORD_DATA | {8'h00, req_bank};
               pos = pos + 2'd1;
               bank_in       = req_bank;
               bank_valid_in = 1'b1;
            end
            sub_hit = sub_valid_ff && !bank_change && sub_ff == req_address;
            if (!sub_hit) begin
               plan.words[pos] = {8'h00, req_address};
               pos = pos + 2'd1;
            end
            plan.words[pos] = WORD_DATA | {8'h00, req_data};
            if (req_address == BANK_SELECT_ADDR) begin
               bank_in       = req_data;
               bank_valid_in = 1'b1;
            end
            sub_in          = req_address + 8'd1;
            sub_valid_in    = req_address != ADDR_MAX;
            second_valid_in = 1'b0;
         end
         CMD_SECOND_WRITE: begin
            if (!(second_valid_ff && second_ff == req_address)) begin
               plan.words[pos] = WORD_SECOND_ADDR | {8'h00, req_address};
               pos = pos + 2'd1;
            end
            plan.words[pos] = WORD_SECOND_DATA | {8'h00, req_data};
            second_in       = req_address + 8'd1;
            second_valid_in = req_address != ADDR_MAX;
            sub_valid_in    = 1'b0;
         end
         CMD_BROADCAST: begin
            plan.words[pos] = WORD_BCAST_ADDR | {8'h00, req_address};
            pos = pos + 2'd1;
            plan.words[pos] = WORD_BCAST_DATA | {8'h00, req_data};
            second_valid_in = 1'b0;
            sub_valid_in    = 1'b0;
         end
         CMD_BANKED_READ: begin
            bank_change = !bank_valid_ff || bank_ff != req_bank;
            if (bank_change) begin
               plan.words[pos] = WORD_BANK_SELECT;
               pos = pos + 2'd1;
               plan.words[pos] = WORD_DATA | {8'h00, req_bank};
               pos = pos + 2'd1;
               bank_in       = req_bank;
               bank_valid_in = 1'b1;
            end
            plan.words[pos] = {8'h00, req_address};
            pos = pos + 2'd1;
            plan.words[pos] = WORD_READ_DUMMY;
            plan.is_read = 1'b1;
            sub_in       = req_address;
            sub_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
      plan.last_index = pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_valid_ff   <= 1'b0;
         sub_valid_ff    <= 1'b0;
         second_valid_ff <= 1'b0;
         bank_ff         <= '0;
         sub_ff          <= '0;
         second_ff       <= '0;
      end else if (push) begin
         bank_valid_ff   <= bank_valid_in;
         sub_valid_ff    <= sub_valid_in;
         second_valid_ff <= second_valid_in;
         bank_ff         <= bank_in;
         sub_ff          <= sub_in;
         second_ff       <= second_in;
      end
   end

endmodule

@@ design/lsrwe_queue.sv @@
// two-entry plan queue between front end and word sequencer
// depends on lsrwe_pkg
module lsrwe_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lsrwe_pkg::plan_type push_plan,
   input  logic                pop,
   output logic                full,
   output lsrwe_pkg::head_type head
);
   import lsrwe_pkg::*;

   plan_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = count_ff == 2'd2;
   assign head.valid = count_ff != 2'd0;
   assign head.plan  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_plan;
      end
   end

endmodule

@@ design/lsrwe_back.sv @@
// word sequencer: walks the head plan and drives the registered result port
// depends on lsrwe_pkg
module lsrwe_back (
   input  logic                clock,
   input  logic                reset,
   input  lsrwe_pkg::head_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [15:0]         rsp_spi_word,
   output logic                rsp_read_slot,
   output logic                rsp_last
);
   import lsrwe_pkg::*;

   logic [1:0]  index_ff, index_in;
   logic        valid_ff, valid_in;
   logic [15:0] word_ff;
   logic        read_slot_ff;
   logic        last_ff;
   logic        load;
   logic        at_last;

   assign load    = head.valid && (!valid_ff || !rsp_stall);
   assign at_last = index_ff == head.plan.last_index;
   assign pop     = load && at_last;

   always_comb begin
      index_in = index_ff;
      if (load) begin
         index_in = at_last ? 2'd0 : index_ff + 2'd1;
      end
      valid_in = load || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff      <= head.plan.words[index_ff];
         read_slot_ff <= head.plan.is_read && at_last;
         last_ff      <= at_last;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_spi_word  = word_ff;
   assign rsp_read_slot = read_slot_ff;
   assign rsp_last      = last_ff;

endmodule

@@ design/lcd_spi_register_write_encoder_core.sv @@
// Register access to SPI word encoder for a two-chip display controller. Each accepted
// access produces one to four 16-bit words, emitted by the word sequencer one per cycle
// on the rsp_ port while rsp_stall is low, the final one flagged by rsp_last. Bank,
// banked sub-address and second-chip address are cached so repeated address words
// are dropped. A two-entry plan queue lets new accesses be accepted while
// words drain.
// top level; depends on lsrwe_pkg, lsrwe_front, lsrwe_queue, lsrwe_back
module lcd_spi_register_write_encoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_bank,
   input  logic [7:0]  req_address,
   input  logic [7:0]  req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_spi_word,
   output logic        rsp_read_slot,
   output logic        rsp_last
);
   import lsrwe_pkg::*;

   logic     push;
   logic     pop;
   logic     full;
   plan_type plan;
   head_type head;

   assign req_stall = full;

   lsrwe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_bank    (req_bank),
      .req_address (req_address),
      .req_data    (req_data),
      .queue_full  (full),
      .push        (push),
      .plan        (plan)
   );

   lsrwe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_plan (plan),
      .pop       (pop),
      .full      (full),
      .head      (head)
   );

   lsrwe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_spi_word  (rsp_spi_word),
      .rsp_read_slot (rsp_read_slot),
      .rsp_last      (rsp_last)
   );

endmodule
